// File: design/eie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eie_pkg
// Opcodes, shift subcodes, condition codes, sizes and the execute-stage
// record shared by the instruction executor modules.
// ----------------------------------------------------------------------------
package eie_pkg;

    localparam int REG_COUNT         = 8;
    localparam int REG_IDX_W         = 3;
    localparam int DEF_RAM_DEPTH     = 64;
    localparam int DEF_STACK_DEPTH   = 16;

    // opcodes (instruction bits 15:11)
    localparam logic [4:0] OP_LOAD_K  = 5'd0;
    localparam logic [4:0] OP_OR_K    = 5'd2;
    localparam logic [4:0] OP_XOR_K   = 5'd3;
    localparam logic [4:0] OP_ADD_K   = 5'd4;
    localparam logic [4:0] OP_ADDCY_K = 5'd5;
    localparam logic [4:0] OP_SUB_K   = 5'd6;
    localparam logic [4:0] OP_SUBCY_K = 5'd7;
    localparam logic [4:0] OP_LOAD_R  = 5'd8;
    localparam logic [4:0] OP_OR_R    = 5'd10;
    localparam logic [4:0] OP_XOR_R   = 5'd11;
    localparam logic [4:0] OP_ADD_R   = 5'd12;
    localparam logic [4:0] OP_ADDCY_R = 5'd13;
    localparam logic [4:0] OP_SUB_R   = 5'd14;
    localparam logic [4:0] OP_SUBCY_R = 5'd15;
    localparam logic [4:0] OP_AND_K   = 5'd16;
    localparam logic [4:0] OP_RETURN  = 5'd18;
    localparam logic [4:0] OP_FETCH_R = 5'd19;
    localparam logic [4:0] OP_SHIFT   = 5'd20;
    localparam logic [4:0] OP_TEST_K  = 5'd21;
    localparam logic [4:0] OP_FETCH_K = 5'd23;
    localparam logic [4:0] OP_JUMP    = 5'd26;
    localparam logic [4:0] OP_CALL    = 5'd27;
    localparam logic [4:0] OP_STORE_R = 5'd28;
    localparam logic [4:0] OP_TEST_R  = 5'd29;
    localparam logic [4:0] OP_STORE_K = 5'd31;

    // shift and rotate subcodes (whole low byte)
    localparam logic [7:0] SH_SLA = 8'h00;
    localparam logic [7:0] SH_SLX = 8'h02;
    localparam logic [7:0] SH_RL  = 8'h04;
    localparam logic [7:0] SH_SL0 = 8'h06;
    localparam logic [7:0] SH_SL1 = 8'h07;
    localparam logic [7:0] SH_SRA = 8'h08;
    localparam logic [7:0] SH_SRX = 8'h0A;
    localparam logic [7:0] SH_RR  = 8'h0C;
    localparam logic [7:0] SH_SR0 = 8'h0E;
    localparam logic [7:0] SH_SR1 = 8'h0F;

    // jump and call conditions
    localparam logic [2:0] CC_Z  = 3'd4;
    localparam logic [2:0] CC_NZ = 3'd5;
    localparam logic [2:0] CC_C  = 3'd6;
    localparam logic [2:0] CC_NC = 3'd7;

    typedef struct packed {
        logic [7:0]           npc;
        logic                 zero;
        logic                 carry;
        logic                 reg_we;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [7:0]           reg_val;
        logic                 ram_we;
        logic [7:0]           ram_opnd;
        logic [7:0]           ram_val;
        logic                 push;
        logic                 pop;
    } exec_t;

    // operand modulo depth, depth in 16..256, by conditional subtraction
    function automatic logic [7:0] fold_addr(input logic [7:0] v, input int depth);
        logic [11:0] r;
        r = {4'd0, v};
        for (int s = 3; s >= 0; s--) begin
            if (r >= 12'(depth << s)) begin
                r = r - 12'(depth << s);
            end
        end
        return r[7:0];
    endfunction

endpackage

// File: design/eie_instr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eie_instr_if
// Instruction channel: valid/ready handshake with the split instruction word.
// ----------------------------------------------------------------------------
interface eie_instr_if;
    logic       valid;
    logic       ready;
    logic [4:0] func;
    logic [2:0] reg_x;
    logic [7:0] low_byte;

    modport source (output valid, func, reg_x, low_byte, input ready);
    modport sink   (input valid, func, reg_x, low_byte, output ready);
endinterface

// File: design/eie_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eie_result_if
// Result channel: valid/ready handshake with next pc, flags and write report.
// ----------------------------------------------------------------------------
interface eie_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] next_pc;
    logic       zero_out;
    logic       carry_out;
    logic       reg_write;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
    logic       ram_write;
    logic [5:0] ram_address;
    logic [7:0] ram_value;

    modport source (output valid, next_pc, zero_out, carry_out, reg_write, reg_index,
                    reg_value, ram_write, ram_address, ram_value, input ready);
    modport sink   (input valid, next_pc, zero_out, carry_out, reg_write, reg_index,
                    reg_value, ram_write, ram_address, ram_value, output ready);
endinterface

// File: design/eie_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eie_mem
// Synchronous memory, one write and one registered read port, with a valid
// bit per entry so that never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module eie_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

// File: design/eie_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eie_alu
// Execute logic: decodes one instruction with its operands and produces the
// next pc, the flags and the register, ram and stack actions.
// ----------------------------------------------------------------------------
module eie_alu (
    input  logic [4:0]          func,
    input  logic [2:0]          xi,
    input  logic [7:0]          k,
    input  logic [7:0]          sx,
    input  logic [7:0]          sy,
    input  logic [7:0]          pc,
    input  logic                carry_in,
    input  logic                zero_in,
    input  logic [7:0]          ram_byte,
    input  logic [7:0]          stack_byte,
    output eie_pkg::exec_t      ex
);
    import eie_pkg::*;

    logic [7:0] operand;
    logic       cin;
    logic [8:0] sum9;
    logic [8:0] sub9;
    logic [7:0] rv;
    logic       we;
    logic       taken;
    logic       hi;
    logic       lo;

    assign operand = func[3] ? sy : k;
    assign cin     = func[0] & carry_in;
    assign sum9    = {1'b0, sx} + {1'b0, operand} + {8'd0, cin};
    assign sub9    = {1'b0, operand} + {8'd0, cin};
    assign hi      = sx[7];
    assign lo      = sx[0];

    always_comb
    begin
        case (xi)
            CC_Z:    taken = zero_in;
            CC_NZ:   taken = !zero_in;
            CC_C:    taken = carry_in;
            CC_NC:   taken = !carry_in;
            default: taken = 1'b1;
        endcase
    end

    always_comb
    begin
        ex          = '0;
        ex.npc      = pc + 8'd1;
        ex.zero     = zero_in;
        ex.carry    = carry_in;
        rv          = '0;
        we          = 1'b0;

        unique case (func) inside
            OP_LOAD_K:
            begin
                rv = k;
                we = 1'b1;
            end
            OP_LOAD_R:
            begin
                rv = sy;
                we = 1'b1;
            end
            OP_AND_K, OP_OR_K, OP_XOR_K, OP_OR_R, OP_XOR_R:
            begin
                case (func)
                    OP_AND_K: rv = sx & k;
                    OP_OR_K:  rv = sx | k;
                    OP_XOR_K: rv = sx ^ k;
                    OP_OR_R:  rv = sx | sy;
                    default:  rv = sx ^ sy;
                endcase
                we       = 1'b1;
                ex.zero  = (rv == 8'd0);
                ex.carry = 1'b0;
            end
            OP_ADD_K, OP_ADDCY_K, OP_ADD_R, OP_ADDCY_R:
            begin
                rv       = sum9[7:0];
                we       = 1'b1;
                ex.carry = sum9[8];
                ex.zero  = (rv == 8'd0);
            end
            OP_SUB_K, OP_SUBCY_K, OP_SUB_R, OP_SUBCY_R:
            begin
                rv       = sx - sub9[7:0];
                we       = 1'b1;
                ex.carry = (sub9 > {1'b0, sx});
                ex.zero  = (rv == 8'd0);
            end
            OP_TEST_K, OP_TEST_R:
            begin
                ex.zero  = ((sx & ((func == OP_TEST_K) ? k : sy)) == 8'd0);
                ex.carry = ^(sx & ((func == OP_TEST_K) ? k : sy));
            end
            OP_FETCH_R, OP_FETCH_K:
            begin
                rv = ram_byte;
                we = 1'b1;
            end
            OP_STORE_R, OP_STORE_K:
            begin
                ex.ram_we   = 1'b1;
                ex.ram_opnd = (func == OP_STORE_R) ? sy : k;
                ex.ram_val  = sx;
            end
            OP_SHIFT:
            begin
                we = 1'b1;
                case (k)
                    SH_RL:   begin rv = {sx[6:0], hi};       ex.carry = hi; end
                    SH_RR:   begin rv = {lo, sx[7:1]};       ex.carry = lo; end
                    SH_SL0:  begin rv = {sx[6:0], 1'b0};     ex.carry = hi; end
                    SH_SL1:  begin rv = {sx[6:0], 1'b1};     ex.carry = hi; end
                    SH_SLA:  begin rv = {sx[6:0], carry_in}; ex.carry = hi; end
                    SH_SLX:  begin rv = {sx[6:0], lo};       ex.carry = hi; end
                    SH_SR0:  begin rv = {1'b0, sx[7:1]};     ex.carry = lo; end
                    SH_SR1:  begin rv = {1'b1, sx[7:1]};     ex.carry = lo; end
                    SH_SRA:  begin rv = {carry_in, sx[7:1]}; ex.carry = lo; end
                    SH_SRX:  begin rv = {hi, sx[7:1]};       ex.carry = lo; end
                    default: we = 1'b0;
                endcase
                // unknown subcode: zero follows the untouched register
                ex.zero = we ? (rv == 8'd0) : (sx == 8'd0);
            end
            OP_JUMP:
            begin
                if (taken)
                begin
                    ex.npc = k;
                end
            end
            OP_CALL:
            begin
                if (taken)
                begin
                    ex.npc  = k;
                    ex.push = 1'b1;
                end
            end
            OP_RETURN:
            begin
                ex.pop = 1'b1;
                ex.npc = stack_byte + 8'd1;
            end
            default:
            begin
            end
        endcase

        ex.reg_we  = we;
        ex.reg_idx = we ? xi : '0;
        ex.reg_val = we ? rv : '0;
    end

endmodule

// File: design/eight_bit_instruction_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_instruction_executor
// Executes one 16-bit instruction per item and reports next pc, flags and
// register or ram writes.
// ----------------------------------------------------------------------------
// Items pass the execute stage and the output register; one item is taken
// every cycle unless execute stalls on a held result or on a FETCH through
// a register pointer, whose second execute phase uses the data ram's single
// read port a second time at the register's value. The register file, data
// ram and return stack are read in the accept cycle and written back from
// the execute stage, with the write of the instruction ahead forwarded into
// the read. All storage reads as zero after reset via per-entry valid bits,
// so there is no clearing pass and the block is ready right after reset.
module eight_bit_instruction_executor #(
    parameter int RAM_DEPTH   = eie_pkg::DEF_RAM_DEPTH,
    parameter int STACK_DEPTH = eie_pkg::DEF_STACK_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    eie_instr_if.sink    instr,
    eie_result_if.source result
);
    import eie_pkg::*;

    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    // execute stage
    logic                 e_valid_reg;
    logic                 e_phase_reg;
    logic [4:0]           e_func_reg;
    logic [2:0]           e_xi_reg;
    logic [7:0]           e_k_reg;
    logic                 x_fwd_reg;
    logic [7:0]           x_fwd_val_reg;
    logic                 y_fwd_reg;
    logic [7:0]           y_fwd_val_reg;
    logic                 ram_fwd_reg;
    logic [7:0]           ram_fwd_val_reg;
    logic                 stk_fwd_reg;
    logic [7:0]           stk_fwd_val_reg;

    // architectural state outside the memories
    logic [7:0]           pc_reg;
    logic                 carry_reg;
    logic                 zero_reg;
    logic [SP_W-1:0]      sp_reg;
    logic [SP_W-1:0]      sp_next;

    // output register
    logic                 out_valid_reg;
    exec_t                out_reg;
    logic [7:0]           out_addr_reg;

    logic [7:0]           rf_x_rdata;
    logic [7:0]           rf_y_rdata;
    logic [7:0]           ram_rdata;
    logic [7:0]           stk_rdata;
    logic [7:0]           sx;
    logic [7:0]           sy;
    exec_t                ex;

    logic                 exec_done;
    logic                 exec_fire;
    logic                 accept;
    logic                 fetch_issue;
    logic                 rf_we;
    logic                 ram_we;
    logic                 ram_re;
    logic                 stk_we;
    logic [7:0]           ram_waddr_full;
    logic [7:0]           ram_kaddr_full;
    logic [7:0]           ram_yaddr_full;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [SP_W-1:0]      sp_inc;
    logic [SP_W-1:0]      sp_dec;
    logic [SP_W-1:0]      stk_raddr;

    assign sx = x_fwd_reg ? x_fwd_val_reg : rf_x_rdata;
    assign sy = y_fwd_reg ? y_fwd_val_reg : rf_y_rdata;

    eie_alu u_alu (
        .func       (e_func_reg),
        .xi         (e_xi_reg),
        .k          (e_k_reg),
        .sx         (sx),
        .sy         (sy),
        .pc         (pc_reg),
        .carry_in   (carry_reg),
        .zero_in    (zero_reg),
        .ram_byte   (ram_fwd_reg ? ram_fwd_val_reg : ram_rdata),
        .stack_byte (stk_fwd_reg ? stk_fwd_val_reg : stk_rdata),
        .ex         (ex)
    );

    assign exec_done   = e_valid_reg && ((e_func_reg != OP_FETCH_R) || e_phase_reg);
    assign exec_fire   = exec_done && (!out_valid_reg || result.ready);
    assign instr.ready = !e_valid_reg || exec_fire;
    assign accept      = instr.valid && instr.ready;
    assign fetch_issue = e_valid_reg && (e_func_reg == OP_FETCH_R) && !e_phase_reg;

    assign rf_we  = exec_fire && ex.reg_we;
    assign ram_we = exec_fire && ex.ram_we;
    assign stk_we = exec_fire && ex.push;

    assign ram_waddr_full = fold_addr(ex.ram_opnd, RAM_DEPTH);
    assign ram_kaddr_full = fold_addr(instr.low_byte, RAM_DEPTH);
    assign ram_yaddr_full = fold_addr(sy, RAM_DEPTH);
    assign ram_re         = accept || fetch_issue;
    assign ram_raddr      = fetch_issue ? ram_yaddr_full[RAM_AW-1:0]
                                        : ram_kaddr_full[RAM_AW-1:0];

    // stack pointer wraps at the depth, which need not be a power of two
    assign sp_inc = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
    always_comb
    begin
        sp_next = sp_reg;
        if (exec_fire && ex.push)
        begin
            sp_next = sp_inc;
        end
        else if (exec_fire && ex.pop)
        begin
            sp_next = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;
        end
    end
    assign sp_dec    = (sp_next == '0) ? SP_LAST : sp_next - 1'b1;
    assign stk_raddr = sp_dec;

    eie_mem #(.DEPTH(REG_COUNT), .WIDTH(8)) u_rf_x (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (ex.reg_idx),
        .wdata (ex.reg_val),
        .re    (accept),
        .raddr (instr.reg_x),
        .rdata (rf_x_rdata)
    );

    eie_mem #(.DEPTH(REG_COUNT), .WIDTH(8)) u_rf_y (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (ex.reg_idx),
        .wdata (ex.reg_val),
        .re    (accept),
        .raddr (instr.low_byte[7:5]),
        .rdata (rf_y_rdata)
    );

    eie_mem #(.DEPTH(RAM_DEPTH), .WIDTH(8)) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (ram_waddr_full[RAM_AW-1:0]),
        .wdata (ex.ram_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    eie_mem #(.DEPTH(STACK_DEPTH), .WIDTH(8)) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (stk_we),
        .waddr (sp_reg),
        .wdata (pc_reg),
        .re    (accept),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            e_phase_reg   <= 1'b0;
            x_fwd_reg     <= 1'b0;
            y_fwd_reg     <= 1'b0;
            ram_fwd_reg   <= 1'b0;
            stk_fwd_reg   <= 1'b0;
            pc_reg        <= '0;
            carry_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                e_valid_reg <= 1'b0;
            end

            if (fetch_issue)
            begin
                e_phase_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                e_phase_reg <= 1'b0;
            end

            // bypass the write that lands at the same edge as the read
            if (accept)
            begin
                x_fwd_reg   <= rf_we && (ex.reg_idx == instr.reg_x);
                y_fwd_reg   <= rf_we && (ex.reg_idx == instr.low_byte[7:5]);
                ram_fwd_reg <= ram_we &&
                               (ram_waddr_full[RAM_AW-1:0] == ram_kaddr_full[RAM_AW-1:0]);
                stk_fwd_reg <= stk_we && (sp_reg == stk_raddr);
            end
            else if (fetch_issue)
            begin
                ram_fwd_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                pc_reg    <= ex.npc;
                carry_reg <= ex.carry;
                zero_reg  <= ex.zero;
            end
            sp_reg <= sp_next;

            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_func_reg      <= instr.func;
            e_xi_reg        <= instr.reg_x;
            e_k_reg         <= instr.low_byte;
            x_fwd_val_reg   <= ex.reg_val;
            y_fwd_val_reg   <= ex.reg_val;
            ram_fwd_val_reg <= ex.ram_val;
            stk_fwd_val_reg <= pc_reg;
        end
        if (exec_fire)
        begin
            out_reg      <= ex;
            out_addr_reg <= ex.ram_we ? ram_waddr_full : 8'd0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_reg.npc;
    assign result.zero_out    = out_reg.zero;
    assign result.carry_out   = out_reg.carry;
    assign result.reg_write   = out_reg.reg_we;
    assign result.reg_index   = out_reg.reg_idx;
    assign result.reg_value   = out_reg.reg_val;
    assign result.ram_write   = out_reg.ram_we;
    assign result.ram_address = out_addr_reg[5:0];
    assign result.ram_value   = out_reg.ram_val;

endmodule

// File: dv/tb_eight_bit_instruction_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_instruction_executor
// Drives instruction items into the executor and checks every result item
// against a cycle-free model of the core kept in the bench: registers, data
// ram, return stack, pc and flags. A short table of directed instructions
// runs first, then random instructions with call/return bursts, random
// stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_eight_bit_instruction_executor;
    import eie_pkg::*;

    localparam int RANDOM_ITEMS   = 1320;
    localparam int QUIET_ITEMS    = 150;
    localparam int LONG_HOLD      = 120;
    localparam int HOLD_AFTER     = 500;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [7:0] SH_UNDEFINED = 8'hFF;
    localparam logic [7:0] SHIFT_CODES [10] = '{SH_RL, SH_RR, SH_SL0, SH_SL1, SH_SLA,
                                                SH_SLX, SH_SR0, SH_SR1, SH_SRA, SH_SRX};
    // opcodes with no effect beyond advancing the pc
    localparam logic [4:0] NOP_OPS [7] = '{5'd1, 5'd9, 5'd17, 5'd22, 5'd24, 5'd25, 5'd30};
    localparam logic [2:0] CC_ALWAYS = 3'd0;

    typedef struct packed {
        logic [7:0] npc;
        logic       zero;
        logic       carry;
        logic       reg_we;
        logic [2:0] reg_idx;
        logic [7:0] reg_val;
        logic       ram_we;
        logic [5:0] ram_addr;
        logic [7:0] ram_val;
    } exec_report_t;

    typedef struct {
        logic [4:0]   func;
        logic [2:0]   reg_x;
        logic [7:0]   low_byte;
        bit           typed;
        exec_report_t want;
    } instr_row_t;

    logic clk = 1'b0;
    logic rst_n;

    eie_instr_if  instr_bus ();
    eie_result_if result_bus ();

    eight_bit_instruction_executor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_bus),
        .result (result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // core state as the bench sees it
    logic [7:0] core_regs [REG_COUNT];
    logic [7:0] core_ram  [DEF_RAM_DEPTH];
    logic [7:0] ret_stack [DEF_STACK_DEPTH];
    logic [3:0] ret_sp;
    logic [7:0] core_pc;
    logic       core_carry;
    logic       core_zero;

    exec_report_t expected_reports [$];
    instr_row_t   directed_rows [$];
    int mismatch_count = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int calls_taken = 0;
    int returns_done = 0;
    int stall_cycles = 0;
    bit quiet_tail = 1'b0;
    bit long_hold_done = 1'b0;

    function automatic bit branch_taken(logic [2:0] cc);
        case (cc)
            CC_Z:    return core_zero;
            CC_NZ:   return !core_zero;
            CC_C:    return core_carry;
            CC_NC:   return !core_carry;
            default: return 1'b1;
        endcase
    endfunction

    function automatic exec_report_t execute_instr(logic [4:0] f, logic [2:0] x, logic [7:0] k);
        exec_report_t r;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] opnd;
        logic [7:0] val;
        logic [8:0] wide;
        logic [8:0] subtrahend;
        sx = core_regs[x];
        sy = core_regs[k[7:5]];
        // register forms of the logic and arithmetic ops have bit 3 set, carry forms bit 0
        opnd = f[3] ? sy : k;
        val = '0;
        r = '0;
        r.npc = core_pc + 8'd1;
        case (f)
            OP_LOAD_K: begin r.reg_we = 1'b1; val = k; end
            OP_LOAD_R: begin r.reg_we = 1'b1; val = sy; end
            OP_AND_K, OP_OR_K, OP_XOR_K, OP_OR_R, OP_XOR_R:
            begin
                if (f == OP_AND_K)
                    val = sx & k;
                else if (f == OP_OR_K || f == OP_OR_R)
                    val = sx | opnd;
                else
                    val = sx ^ opnd;
                r.reg_we = 1'b1;
                core_zero = (val == 8'd0);
                core_carry = 1'b0;
            end
            OP_ADD_K, OP_ADDCY_K, OP_ADD_R, OP_ADDCY_R:
            begin
                wide = {1'b0, sx} + {1'b0, opnd} + 9'(f[0] & core_carry);
                val = wide[7:0];
                r.reg_we = 1'b1;
                core_carry = wide[8];
                core_zero = (val == 8'd0);
            end
            OP_SUB_K, OP_SUBCY_K, OP_SUB_R, OP_SUBCY_R:
            begin
                subtrahend = {1'b0, opnd} + 9'(f[0] & core_carry);
                wide = {1'b0, sx} - subtrahend;
                val = wide[7:0];
                r.reg_we = 1'b1;
                core_carry = (subtrahend > {1'b0, sx});
                core_zero = (val == 8'd0);
            end
            OP_TEST_K, OP_TEST_R:
            begin
                val = sx & ((f == OP_TEST_K) ? k : sy);
                core_zero = (val == 8'd0);
                core_carry = ^val;
            end
            OP_FETCH_R: begin r.reg_we = 1'b1; val = core_ram[sy[5:0]]; end
            OP_FETCH_K: begin r.reg_we = 1'b1; val = core_ram[k[5:0]]; end
            OP_STORE_R, OP_STORE_K:
            begin
                r.ram_we = 1'b1;
                r.ram_addr = (f == OP_STORE_R) ? sy[5:0] : k[5:0];
                r.ram_val = sx;
                core_ram[r.ram_addr] = sx;
            end
            OP_SHIFT:
            begin
                r.reg_we = 1'b1;
                case (k)
                    SH_RL:  begin val = {sx[6:0], sx[7]};      core_carry = sx[7]; end
                    SH_RR:  begin val = {sx[0], sx[7:1]};      core_carry = sx[0]; end
                    SH_SL0: begin val = {sx[6:0], 1'b0};       core_carry = sx[7]; end
                    SH_SL1: begin val = {sx[6:0], 1'b1};       core_carry = sx[7]; end
                    SH_SLA: begin val = {sx[6:0], core_carry}; core_carry = sx[7]; end
                    SH_SLX: begin val = {sx[6:0], sx[0]};      core_carry = sx[7]; end
                    SH_SR0: begin val = {1'b0, sx[7:1]};       core_carry = sx[0]; end
                    SH_SR1: begin val = {1'b1, sx[7:1]};       core_carry = sx[0]; end
                    SH_SRA: begin val = {core_carry, sx[7:1]}; core_carry = sx[0]; end
                    SH_SRX: begin val = {sx[7], sx[7:1]};      core_carry = sx[0]; end
                    default: r.reg_we = 1'b0;
                endcase
                // undefined subcode leaves the register but still sets zero from it
                core_zero = r.reg_we ? (val == 8'd0) : (sx == 8'd0);
            end
            OP_JUMP:
            begin
                if (branch_taken(x))
                    r.npc = k;
            end
            OP_CALL:
            begin
                if (branch_taken(x))
                begin
                    ret_stack[ret_sp] = core_pc;
                    ret_sp = ret_sp + 4'd1;
                    r.npc = k;
                    calls_taken++;
                end
            end
            OP_RETURN:
            begin
                ret_sp = ret_sp - 4'd1;
                r.npc = ret_stack[ret_sp] + 8'd1;
                returns_done++;
            end
            default: ;
        endcase
        if (r.reg_we)
        begin
            core_regs[x] = val;
            r.reg_idx = x;
            r.reg_val = val;
        end
        core_pc = r.npc;
        r.zero = core_zero;
        r.carry = core_carry;
        return r;
    endfunction

    function automatic instr_row_t plain_row(logic [4:0] f, logic [2:0] x, logic [7:0] k);
        instr_row_t row;
        row.func = f;
        row.reg_x = x;
        row.low_byte = k;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic instr_row_t typed_row(logic [4:0] f, logic [2:0] x, logic [7:0] k,
                                             exec_report_t want);
        instr_row_t row;
        row = plain_row(f, x, k);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    task automatic issue_instr(logic [4:0] f, logic [2:0] x, logic [7:0] k,
                               bit typed, exec_report_t want);
        exec_report_t pred;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            instr_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        instr_bus.valid    <= 1'b1;
        instr_bus.func     <= f;
        instr_bus.reg_x    <= x;
        instr_bus.low_byte <= k;
        @(posedge clk);
        while (!instr_bus.ready)
            @(posedge clk);
        pred = execute_instr(f, x, k);
        expected_reports.push_back(typed ? want : pred);
        items_accepted++;
        @(negedge clk);
    endtask

    task automatic choose_instr(input int n, output logic [4:0] f, output logic [2:0] x,
                                output logic [7:0] k);
        int sel;
        sel = $urandom_range(0, 99);
        f = 5'($urandom_range(0, 31));
        x = 3'($urandom_range(0, 7));
        k = 8'($urandom);
        // a run of unconditional calls overflows the stack, then returns pop stale entries
        if (n % 300 >= 100 && n % 300 < 120)
        begin
            f = OP_CALL;
            x = 3'($urandom_range(0, 3));
        end
        else if (n % 300 >= 120 && n % 300 < 140)
            f = OP_RETURN;
        else if (sel < 10)
        begin
            f = OP_SHIFT;
            if (sel != 0)
                k = SHIFT_CODES[$urandom_range(0, 9)];
        end
        else if (sel < 18)
            f = OP_CALL;
        else if (sel < 26)
            f = OP_RETURN;
        else if (sel < 32)
            f = OP_JUMP;
        else if (sel < 36)
            f = NOP_OPS[$urandom_range(0, 6)];
        else if (sel < 44)
            f = (sel % 2 == 0) ? OP_STORE_R : OP_STORE_K;
        else if (sel < 52)
            f = (sel % 2 == 0) ? OP_FETCH_R : OP_FETCH_K;
    endtask

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        exec_report_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            results_checked++;
            if (expected_reports.size() == 0)
            begin
                $display("%0t: result item with nothing expected, expected none actual pc %0h",
                         $time, result_bus.next_pc);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("next_pc", want.npc, result_bus.next_pc);
                check_field("zero_out", 8'(want.zero), 8'(result_bus.zero_out));
                check_field("carry_out", 8'(want.carry), 8'(result_bus.carry_out));
                check_field("reg_write", 8'(want.reg_we), 8'(result_bus.reg_write));
                check_field("reg_index", 8'(want.reg_idx), 8'(result_bus.reg_index));
                check_field("reg_value", want.reg_val, result_bus.reg_value);
                check_field("ram_write", 8'(want.ram_we), 8'(result_bus.ram_write));
                check_field("ram_address", 8'(want.ram_addr), 8'(result_bus.ram_address));
                check_field("ram_value", want.ram_val, result_bus.ram_value);
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("tb_eight_bit_instruction_executor NOT OK");
            $finish;
        end
    end

    initial
    begin : result_sink
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && items_accepted >= HOLD_AFTER)
            begin
                // long hold-off so the executor backs up and stalls its input
                long_hold_done = 1'b1;
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [4:0] f;
        logic [2:0] x;
        logic [7:0] k;
        instr_bus.valid = 1'b0;
        instr_bus.func = '0;
        instr_bus.reg_x = '0;
        instr_bus.low_byte = '0;
        rst_n = 1'b0;
        foreach (core_regs[i]) core_regs[i] = '0;
        foreach (core_ram[i]) core_ram[i] = '0;
        foreach (ret_stack[i]) ret_stack[i] = '0;
        ret_sp = '0;
        core_pc = '0;
        core_carry = 1'b0;
        core_zero = 1'b0;

        // expected items laid out as {npc, z, c, reg_we, idx, val, ram_we, addr, byte}
        directed_rows.push_back(typed_row(OP_LOAD_K, 3'd0, 8'hFF,
            {8'd1, 1'b0, 1'b0, 1'b1, 3'd0, 8'hFF, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(OP_LOAD_K, 3'd7, 8'h00,
            {8'd2, 1'b0, 1'b0, 1'b1, 3'd7, 8'h00, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(OP_ADD_K, 3'd0, 8'h01,
            {8'd3, 1'b1, 1'b1, 1'b1, 3'd0, 8'h00, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(OP_ADDCY_K, 3'd0, 8'hFF,
            {8'd4, 1'b1, 1'b1, 1'b1, 3'd0, 8'h00, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(OP_SUBCY_K, 3'd7, 8'hFF,
            {8'd5, 1'b1, 1'b1, 1'b1, 3'd7, 8'h00, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(OP_SUB_K, 3'd7, 8'h01,
            {8'd6, 1'b0, 1'b1, 1'b1, 3'd7, 8'hFF, 1'b0, 6'd0, 8'h00}));
        // address 0xFF folds to the top ram entry
        directed_rows.push_back(typed_row(OP_STORE_K, 3'd7, 8'hFF,
            {8'd7, 1'b0, 1'b1, 1'b0, 3'd0, 8'h00, 1'b1, 6'h3F, 8'hFF}));
        directed_rows.push_back(typed_row(OP_FETCH_K, 3'd1, 8'h3F,
            {8'd8, 1'b0, 1'b1, 1'b1, 3'd1, 8'hFF, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(NOP_OPS[0], 3'd5, 8'hAA,
            {8'd9, 1'b0, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(typed_row(OP_JUMP, CC_ALWAYS, 8'hFF,
            {8'hFF, 1'b0, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0, 6'd0, 8'h00}));
        // pc wraps past 0xFF
        directed_rows.push_back(typed_row(OP_LOAD_K, 3'd2, 8'hE0,
            {8'h00, 1'b0, 1'b1, 1'b1, 3'd2, 8'hE0, 1'b0, 6'd0, 8'h00}));
        directed_rows.push_back(plain_row(OP_XOR_K, 3'd0, 8'h00));
        directed_rows.push_back(plain_row(OP_OR_K, 3'd3, 8'h81));
        directed_rows.push_back(plain_row(OP_AND_K, 3'd3, 8'h7E));
        directed_rows.push_back(plain_row(OP_LOAD_R, 3'd4, 8'h20));
        directed_rows.push_back(plain_row(OP_OR_R, 3'd5, 8'hE0));
        directed_rows.push_back(plain_row(OP_XOR_R, 3'd4, 8'h20));
        directed_rows.push_back(plain_row(OP_ADD_R, 3'd1, 8'h80));
        directed_rows.push_back(plain_row(OP_ADDCY_R, 3'd1, 8'h20));
        directed_rows.push_back(plain_row(OP_SUBCY_R, 3'd6, 8'hC0));
        directed_rows.push_back(plain_row(OP_SUB_R, 3'd6, 8'h20));
        directed_rows.push_back(plain_row(OP_TEST_K, 3'd1, 8'h07));
        directed_rows.push_back(plain_row(OP_TEST_R, 3'd1, 8'h20));
        directed_rows.push_back(plain_row(OP_STORE_R, 3'd1, 8'hE0));
        directed_rows.push_back(plain_row(OP_FETCH_R, 3'd2, 8'hE0));
        directed_rows.push_back(plain_row(OP_SHIFT, 3'd1, SH_SLX));
        directed_rows.push_back(plain_row(OP_SHIFT, 3'd3, SH_UNDEFINED));
        directed_rows.push_back(plain_row(OP_CALL, CC_C, 8'h40));
        directed_rows.push_back(plain_row(OP_RETURN, 3'd0, 8'h00));
        directed_rows.push_back(plain_row(OP_RETURN, 3'd0, 8'h00));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            issue_instr(directed_rows[i].func, directed_rows[i].reg_x,
                        directed_rows[i].low_byte, directed_rows[i].typed,
                        directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            choose_instr(n, f, x, k);
            issue_instr(f, x, k, 1'b0, '0);
        end
        instr_bus.valid <= 1'b0;

        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("issued %0d instructions (%0d directed), checked %0d results", items_accepted,
                 directed_rows.size(), results_checked);
        $display("taken calls %0d, returns %0d, long output hold-off %0s", calls_taken,
                 returns_done, long_hold_done ? "done" : "missed");
        if (mismatch_count == 0)
            $display("tb_eight_bit_instruction_executor OK");
        else
            $display("tb_eight_bit_instruction_executor NOT OK");
        $finish;
    end

endmodule
